FILE: rtl/tdc_pkg.sv
// Package for the triangle degeneracy classifier: field widths, payload
// structs, register and class codes, and the cosine sign helper.
// No dependencies.
`default_nettype none

package tdc_pkg;

   localparam int COORD_BITS = 16;
   localparam int INDEX_BITS = 24;
   localparam int AREA_BITS  = 35;
   localparam int COS_BITS   = 16;
   localparam int COS_FRAC   = 15;
   localparam int CSR_IDX_BITS = 2;

   // derived datapath widths
   localparam int DIFF_BITS = COORD_BITS + 1;        // edge component
   localparam int PROD_BITS = 2 * DIFF_BITS;         // component product
   localparam int SUM_BITS  = PROD_BITS + 2;         // dot / cross sum, signed
   localparam int MAG_BITS  = PROD_BITS;             // magnitudes and lengths
   localparam int SQ_BITS   = 2 * MAG_BITS;          // squares, len products
   localparam int CSQ_BITS  = 2 * COS_BITS - 1;      // cosine limit squared
   localparam int RHS_BITS  = SQ_BITS + CSQ_BITS;
   localparam int ASQ_BITS  = 2 * AREA_BITS;
   localparam int CSUM_BITS = (SQ_BITS + 2 > ASQ_BITS) ? SQ_BITS + 2 : ASQ_BITS;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_AREA_LIMIT = 2'd0,
      CSR_MAX_COS    = 2'd1,
      CSR_MIN_COS    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_SMALL  = 2'd1,
      KIND_OBTUSE = 2'd2,
      KIND_NEEDLE = 2'd3
   } kind_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]        face_index;
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] az;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by_coord;
      logic signed [COORD_BITS-1:0] bz;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic signed [COORD_BITS-1:0] cz;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] face_out;
      kind_type              kind;
   } rsp_payload_type;

   // Sign of dot*2^15 - c*|u||w|, returned as {negative, positive}.
   // lhs_gt / lhs_lt compare the squared magnitudes.
   function automatic logic [1:0] cos_sign(input logic d_pos, input logic d_neg,
                                           input logic c_pos, input logic c_neg,
                                           input logic lhs_gt, input logic lhs_lt);
      logic [1:0] r;
      if (!d_neg && c_neg) begin
         r = 2'b01;
      end else if (!d_pos && c_pos) begin
         r = 2'b10;
      end else if (!d_pos && !d_neg) begin
         r = 2'b00;
      end else if (d_pos) begin
         r = {lhs_lt, lhs_gt};
      end else begin
         r = {lhs_gt, lhs_lt};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/tdc_mul.sv
// Two-stage unsigned multiplier: first operand split in halves, partial
// products registered, then summed into the output register. Uses no package.
`default_nettype none

module tdc_mul #(
   parameter int AW = 34,
   parameter int BW = 34
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [AW-1:0]    a,
   input  wire logic [BW-1:0]    b,
   output logic      [AW+BW-1:0] p
);

   localparam int LW = (AW + 1) / 2;
   localparam int HW = AW - LW;
   localparam int PW = AW + BW;

   logic [LW+BW-1:0] lo_ff, lo_in;
   logic [HW+BW-1:0] hi_ff, hi_in;
   logic [PW-1:0]    p_ff, p_in;

   always_comb begin
      lo_in = (LW+BW)'(a[LW-1:0]) * (LW+BW)'(b);
      hi_in = (HW+BW)'(a[AW-1:LW]) * (HW+BW)'(b);
      p_in  = PW'(lo_ff) + (PW'(hi_ff) << LW);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

FILE: rtl/triangle_degeneracy_classifier_core.sv
// Triangle degeneracy classifier top level: nine-stage pipeline from vertices
// to class. Depends on tdc_pkg and tdc_mul.
//
//  port group    dir   role
//  req_*         in    triangle (face index, three vertices), valid/stall
//  rsp_*         out   face index and class, valid/stall
//  csr_*         in    register writes: area limit, obtuse cos, needle cos
//
// One transfer per cycle in and out unless the output stalls. Stages 5-8 are
// the two split multiplier rings (length squares, then times cos limit squared).
// All stages advance together whenever the output register is empty or taken;
// a stalled output freezes the whole pipeline and stalls the input.
// Synchronous reset clears the valid bits and area limit, sets default cosines.
`default_nettype none

module triangle_degeneracy_classifier_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire tdc_pkg::req_payload_type      req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output tdc_pkg::rsp_payload_type           rsp_payload,
   input  wire logic                          csr_we,
   input  wire logic [tdc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [tdc_pkg::AREA_BITS-1:0] csr_wdata
);

   localparam int CW   = tdc_pkg::COORD_BITS;
   localparam int DW   = tdc_pkg::DIFF_BITS;
   localparam int PW   = tdc_pkg::PROD_BITS;
   localparam int SW   = tdc_pkg::SUM_BITS;
   localparam int MW   = tdc_pkg::MAG_BITS;
   localparam int QW   = tdc_pkg::SQ_BITS;
   localparam int KW   = tdc_pkg::CSQ_BITS;
   localparam int RW   = tdc_pkg::RHS_BITS;
   localparam int AW   = tdc_pkg::AREA_BITS;
   localparam int GW   = tdc_pkg::COS_BITS;
   localparam int XW   = tdc_pkg::CSUM_BITS;
   localparam int IW   = tdc_pkg::INDEX_BITS;

   typedef struct packed {
      logic [IW-1:0] face;
      logic          zero_edge;
      logic          cross_nz;
      logic [2:0]    d_pos;
      logic [2:0]    d_neg;
   } side_type;

   // ---------------- configuration ----------------
   logic [AW-1:0]        area_limit_ff;
   logic signed [GW-1:0] max_cos_ff, min_cos_ff;
   logic [KW-1:0]        csq_max_ff, csq_max_in, csq_min_ff, csq_min_in;
   logic [2*AW-1:0]      area_sq;
   logic [GW-1:0]        max_mag, min_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         area_limit_ff <= '0;
         max_cos_ff    <= -GW'(16384);
         min_cos_ff    <= GW'(30792);
      end else if (csr_we) begin
         unique case (tdc_pkg::csr_index_type'(csr_index))
            tdc_pkg::CSR_AREA_LIMIT: area_limit_ff <= csr_wdata;
            tdc_pkg::CSR_MAX_COS:    max_cos_ff    <= csr_wdata[GW-1:0];
            tdc_pkg::CSR_MIN_COS:    min_cos_ff    <= csr_wdata[GW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      max_mag    = max_cos_ff[GW-1] ? GW'(-max_cos_ff) : GW'(max_cos_ff);
      min_mag    = min_cos_ff[GW-1] ? GW'(-min_cos_ff) : GW'(min_cos_ff);
      csq_max_in = KW'(max_mag) * KW'(max_mag);
      csq_min_in = KW'(min_mag) * KW'(min_mag);
   end

   always_ff @(posedge clock) begin
      csq_max_ff <= csq_max_in;
      csq_min_ff <= csq_min_in;
   end

   // squared area limit, registered through the split multiplier after a write
   tdc_mul #(.AW(AW), .BW(AW)) u_area_sq (
      .clock(clock), .en(1'b1), .a(area_limit_ff), .b(area_limit_ff), .p(area_sq)
   );

   // ---------------- pipeline control ----------------
   logic [9:1] vld_ff;
   logic       en;

   assign en        = !vld_ff[9] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[9];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[8:1], req_valid};
      end
   end

   // ---------------- stage 1: edge vectors ----------------
   logic signed [CW-1:0] va [3], vb [3], vc [3];
   logic signed [DW-1:0] ab_ff [3], ac_ff [3], bc_ff [3];
   logic [IW-1:0]        face1_ff, face2_ff, face3_ff;

   always_comb begin
      va[0] = req_payload.ax;  va[1] = req_payload.ay;       va[2] = req_payload.az;
      vb[0] = req_payload.bx;  vb[1] = req_payload.by_coord; vb[2] = req_payload.bz;
      vc[0] = req_payload.cx;  vc[1] = req_payload.cy;       vc[2] = req_payload.cz;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         face1_ff <= req_payload.face_index;
         for (int i = 0; i < 3; i++) begin
            ab_ff[i] <= DW'(vb[i]) - DW'(va[i]);
            ac_ff[i] <= DW'(vc[i]) - DW'(va[i]);
            bc_ff[i] <= DW'(vc[i]) - DW'(vb[i]);
         end
      end
   end

   // ---------------- stage 2: component products ----------------
   // cp: cross terms; dp rows: ab.ab, ac.ac, bc.bc, ab.ac, ab.bc, ac.bc
   logic signed [PW-1:0] cp_ff [6];
   logic signed [PW-1:0] dp_ff [6][3];

   always_ff @(posedge clock) begin
      if (en) begin
         face2_ff <= face1_ff;
         cp_ff[0] <= PW'(ab_ff[1]) * PW'(ac_ff[2]);
         cp_ff[1] <= PW'(ab_ff[2]) * PW'(ac_ff[1]);
         cp_ff[2] <= PW'(ab_ff[2]) * PW'(ac_ff[0]);
         cp_ff[3] <= PW'(ab_ff[0]) * PW'(ac_ff[2]);
         cp_ff[4] <= PW'(ab_ff[0]) * PW'(ac_ff[1]);
         cp_ff[5] <= PW'(ab_ff[1]) * PW'(ac_ff[0]);
         for (int i = 0; i < 3; i++) begin
            dp_ff[0][i] <= PW'(ab_ff[i]) * PW'(ab_ff[i]);
            dp_ff[1][i] <= PW'(ac_ff[i]) * PW'(ac_ff[i]);
            dp_ff[2][i] <= PW'(bc_ff[i]) * PW'(bc_ff[i]);
            dp_ff[3][i] <= PW'(ab_ff[i]) * PW'(ac_ff[i]);
            dp_ff[4][i] <= PW'(ab_ff[i]) * PW'(bc_ff[i]);
            dp_ff[5][i] <= PW'(ac_ff[i]) * PW'(bc_ff[i]);
         end
      end
   end

   // ---------------- stage 3: sums ----------------
   // sum: lab, lac, lbc, dot at A, dot at B, dot at C
   logic signed [SW-1:0] cr_ff [3];
   logic signed [SW-1:0] sum_ff [6];
   logic signed [SW-1:0] dsum [6];

   always_comb begin
      for (int r = 0; r < 6; r++) begin
         dsum[r] = SW'(dp_ff[r][0]) + SW'(dp_ff[r][1]) + SW'(dp_ff[r][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         face3_ff <= face2_ff;
         for (int i = 0; i < 3; i++) begin
            cr_ff[i] <= SW'(cp_ff[2*i]) - SW'(cp_ff[2*i+1]);
         end
         sum_ff[0] <= dsum[0];
         sum_ff[1] <= dsum[1];
         sum_ff[2] <= dsum[2];
         sum_ff[3] <= dsum[3];
         sum_ff[4] <= -dsum[4];     // ba.bc = -(ab.bc)
         sum_ff[5] <= dsum[5];      // ca.cb = ac.bc
      end
   end

   // ---------------- stage 4: magnitudes and flags ----------------
   logic [MW-1:0] crm_ff [3], dm_ff [3], len_ff [3];
   side_type      side_ff [4:8];
   side_type      side4_in;

   always_comb begin
      side4_in.face      = face3_ff;
      side4_in.zero_edge = (sum_ff[0] == '0) || (sum_ff[1] == '0) || (sum_ff[2] == '0);
      side4_in.cross_nz  = (cr_ff[0] != '0) || (cr_ff[1] != '0) || (cr_ff[2] != '0);
      for (int i = 0; i < 3; i++) begin
         side4_in.d_pos[i] = !sum_ff[3+i][SW-1] && (sum_ff[3+i] != '0);
         side4_in.d_neg[i] = sum_ff[3+i][SW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[4] <= side4_in;
         for (int k = 5; k <= 8; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            crm_ff[i] <= cr_ff[i][SW-1] ? MW'(-cr_ff[i]) : MW'(cr_ff[i]);
            dm_ff[i]  <= sum_ff[3+i][SW-1] ? MW'(-sum_ff[3+i]) : MW'(sum_ff[3+i]);
            len_ff[i] <= MW'(sum_ff[i]);
         end
      end
   end

   // ---------------- stages 5-6: squares and length products ----------------
   logic [QW-1:0] crsq [3], dsq [3], uw [3];

   for (genvar k = 0; k < 3; k++) begin : g_sq
      tdc_mul #(.AW(MW), .BW(MW)) u_crsq (
         .clock(clock), .en(en), .a(crm_ff[k]), .b(crm_ff[k]), .p(crsq[k])
      );
      tdc_mul #(.AW(MW), .BW(MW)) u_dsq (
         .clock(clock), .en(en), .a(dm_ff[k]), .b(dm_ff[k]), .p(dsq[k])
      );
      // angle A: ab,ac   angle B: ab,bc   angle C: ac,bc
      tdc_mul #(.AW(MW), .BW(MW)) u_uw (
         .clock(clock), .en(en),
         .a(len_ff[(k == 2) ? 1 : 0]), .b(len_ff[(k == 0) ? 1 : 2]), .p(uw[k])
      );
   end

   // ---------------- stages 7-8: area sum, cosine products ----------------
   logic [XW-1:0] csum_ff;
   logic [QW-1:0] dsq7_ff [3], dsq8_ff [3];
   logic          small_ff;
   logic [RW-1:0] rhs_max [3], rhs_min [3];

   for (genvar k = 0; k < 3; k++) begin : g_rhs
      tdc_mul #(.AW(QW), .BW(KW)) u_rmax (
         .clock(clock), .en(en), .a(uw[k]), .b(csq_max_ff), .p(rhs_max[k])
      );
      tdc_mul #(.AW(QW), .BW(KW)) u_rmin (
         .clock(clock), .en(en), .a(uw[k]), .b(csq_min_ff), .p(rhs_min[k])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         csum_ff  <= XW'(crsq[0]) + XW'(crsq[1]) + XW'(crsq[2]);
         small_ff <= csum_ff < XW'(area_sq);
         for (int i = 0; i < 3; i++) begin
            dsq7_ff[i] <= dsq[i];
            dsq8_ff[i] <= dsq7_ff[i];
         end
      end
   end

   // ---------------- stage 9: angle tests and class ----------------
   logic [RW-1:0]           lhs [3];
   logic [1:0]              sg_max [3], sg_min [3];
   logic                    obtuse, needle;
   tdc_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   always_comb begin
      obtuse = 1'b0;
      needle = 1'b0;
      for (int i = 0; i < 3; i++) begin
         lhs[i]    = RW'(dsq8_ff[i]) << (2 * tdc_pkg::COS_FRAC);
         sg_max[i] = tdc_pkg::cos_sign(side_ff[8].d_pos[i], side_ff[8].d_neg[i],
                        !max_cos_ff[GW-1] && (max_cos_ff != '0), max_cos_ff[GW-1],
                        lhs[i] > rhs_max[i], lhs[i] < rhs_max[i]);
         sg_min[i] = tdc_pkg::cos_sign(side_ff[8].d_pos[i], side_ff[8].d_neg[i],
                        !min_cos_ff[GW-1] && (min_cos_ff != '0), min_cos_ff[GW-1],
                        lhs[i] > rhs_min[i], lhs[i] < rhs_min[i]);
         obtuse = obtuse | sg_max[i][1];
         needle = needle | sg_min[i][0];
      end
      // no angle on a zero edge; collinear faces are never obtuse
      obtuse = obtuse && side_ff[8].cross_nz && !side_ff[8].zero_edge;
      needle = needle && !side_ff[8].zero_edge;

      rsp_payload_in.face_out = side_ff[8].face;
      if (small_ff) begin
         rsp_payload_in.kind = tdc_pkg::KIND_SMALL;
      end else if (obtuse) begin
         rsp_payload_in.kind = tdc_pkg::KIND_OBTUSE;
      end else if (needle) begin
         rsp_payload_in.kind = tdc_pkg::KIND_NEEDLE;
      end else begin
         rsp_payload_in.kind = tdc_pkg::KIND_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_payload = rsp_payload_ff;

   // ---------------- assertions ----------------
   a_flush_on_reset: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("valid bits not cleared by reset");

   a_frozen_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved while output stalled");

   a_stage8_lands: assert property (@(posedge clock) disable iff (reset)
      en && vld_ff[8] |=> rsp_valid)
      else $error("item from stage 8 lost before output");

   a_zero_edge_no_angle: assert property (@(posedge clock) disable iff (reset)
      en && vld_ff[8] && side_ff[8].zero_edge |=>
         (rsp_payload.kind == tdc_pkg::KIND_NONE) || (rsp_payload.kind == tdc_pkg::KIND_SMALL))
      else $error("angle class given for a zero-length edge");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for triangle_degeneracy_classifier_core: a directed table, then random
// triangles under several register settings, checked against an in-bench predictor.
// Depends on tdc_pkg and the RTL top level.
`default_nettype none

module tb;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int AREA_W  = tdc_pkg::AREA_BITS;
   localparam int COS_W   = tdc_pkg::COS_BITS;
   localparam int COORD_W = tdc_pkg::COORD_BITS;
   localparam int INDEX_W = tdc_pkg::INDEX_BITS;

   typedef struct {
      logic [AREA_W-1:0]        area;
      logic signed [COS_W-1:0]  maxc;
      logic signed [COS_W-1:0]  minc;
      tdc_pkg::req_payload_type tri_in;
      bit                       typed;
      tdc_pkg::kind_type        kind;
   } dir_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   tdc_pkg::req_payload_type req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   tdc_pkg::rsp_payload_type rsp_payload;
   logic                     csr_we;
   logic [tdc_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [AREA_W-1:0]        csr_wdata;

   // shadow copy of the block's registers
   logic [AREA_W-1:0]       area_limit;
   logic signed [COS_W-1:0] obtuse_cos;
   logic signed [COS_W-1:0] needle_cos;

   tdc_pkg::rsp_payload_type expected_q[$];
   dir_row_type              dir_rows[$];
   int                       errors;
   int                       cycles;
   bit                       calm;

   triangle_degeneracy_classifier_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------- predictor ----------------
   function automatic logic [127:0] square_mag(input longint v);
      logic [127:0] m;
      m = (v < 0) ? -v : v;
      return m * m;
   endfunction

   // sign of dot*2^15 - c*sqrt(uu*ww)
   function automatic int cos_sign_of(input longint dot, input longint uu,
                                      input longint ww, input int c);
      logic [127:0] d, lhs, rhs;
      int r;
      if (dot >= 0 && c < 0) return 1;
      if (dot <= 0 && c > 0) return -1;
      if (dot == 0) return 0;
      d   = ((dot < 0) ? -dot : dot);
      d   = d * 128'd32768;
      lhs = d * d;
      rhs = square_mag(c) * 128'(uu) * 128'(ww);
      r   = (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
      return (dot > 0) ? r : -r;
   endfunction

   function automatic longint dot3(input longint u[3], input longint w[3]);
      return u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
   endfunction

   function automatic tdc_pkg::kind_type classify(input tdc_pkg::req_payload_type p);
      longint a[3], b[3], c[3], ab[3], ac[3], bc[3], ba[3], ca[3], cb[3], cr[3];
      longint lab, lac, lbc, da, db, dc;
      logic [127:0] cross_sq;
      int tmax, tmin;
      bit small_area, obtuse, needle;
      a = '{p.ax, p.ay, p.az};
      b = '{p.bx, p.by_coord, p.bz};
      c = '{p.cx, p.cy, p.cz};
      for (int i = 0; i < 3; i++) begin
         ab[i] = b[i] - a[i];
         ac[i] = c[i] - a[i];
         bc[i] = c[i] - b[i];
         ba[i] = -ab[i];
         ca[i] = -ac[i];
         cb[i] = -bc[i];
      end
      cr[0] = ab[1] * ac[2] - ab[2] * ac[1];
      cr[1] = ab[2] * ac[0] - ab[0] * ac[2];
      cr[2] = ab[0] * ac[1] - ab[1] * ac[0];
      cross_sq = square_mag(cr[0]) + square_mag(cr[1]) + square_mag(cr[2]);
      small_area = cross_sq < square_mag(longint'(area_limit));
      lab = dot3(ab, ab);
      lac = dot3(ac, ac);
      lbc = dot3(bc, bc);
      obtuse = 0;
      needle = 0;
      tmax = obtuse_cos;
      tmin = needle_cos;
      if (lab != 0 && lac != 0 && lbc != 0) begin
         da = dot3(ab, ac);
         db = dot3(ba, bc);
         dc = dot3(ca, cb);
         // a straight angle is not obtuse
         if (cr[0] != 0 || cr[1] != 0 || cr[2] != 0)
            obtuse = cos_sign_of(da, lab, lac, tmax) < 0 ||
                     cos_sign_of(db, lab, lbc, tmax) < 0 ||
                     cos_sign_of(dc, lac, lbc, tmax) < 0;
         needle = cos_sign_of(da, lab, lac, tmin) > 0 ||
                  cos_sign_of(db, lab, lbc, tmin) > 0 ||
                  cos_sign_of(dc, lac, lbc, tmin) > 0;
      end
      if (small_area) return tdc_pkg::KIND_SMALL;
      if (obtuse) return tdc_pkg::KIND_OBTUSE;
      if (needle) return tdc_pkg::KIND_NEEDLE;
      return tdc_pkg::KIND_NONE;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic tdc_pkg::req_payload_type tri_of(input int face, input int ax,
                                                       input int ay, input int az,
                                                       input int bx, input int by_c,
                                                       input int bz, input int cx,
                                                       input int cy, input int cz);
      tdc_pkg::req_payload_type p;
      p.face_index = INDEX_W'(face);
      p.ax = COORD_W'(ax); p.ay = COORD_W'(ay); p.az = COORD_W'(az);
      p.bx = COORD_W'(bx); p.by_coord = COORD_W'(by_c); p.bz = COORD_W'(bz);
      p.cx = COORD_W'(cx); p.cy = COORD_W'(cy); p.cz = COORD_W'(cz);
      return p;
   endfunction

   task automatic add_row(input logic [AREA_W-1:0] area, input int maxc, input int minc,
                          input tdc_pkg::req_payload_type p, input bit typed,
                          input tdc_pkg::kind_type k);
      dir_row_type r;
      r.area = area; r.maxc = COS_W'(maxc); r.minc = COS_W'(minc);
      r.tri_in = p; r.typed = typed; r.kind = k;
      dir_rows = {dir_rows, r};
   endtask

   task automatic wait_idle();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input tdc_pkg::csr_index_type idx,
                            input logic [AREA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         tdc_pkg::CSR_AREA_LIMIT: area_limit = data;
         tdc_pkg::CSR_MAX_COS:    obtuse_cos = data[COS_W-1:0];
         default:                 needle_cos = data[COS_W-1:0];
      endcase
   endtask

   task automatic load_settings(input logic [AREA_W-1:0] area, input int maxc,
                                input int minc);
      wait_idle();
      write_reg(tdc_pkg::CSR_AREA_LIMIT, area);
      write_reg(tdc_pkg::CSR_MAX_COS, AREA_W'(maxc[COS_W-1:0]));
      write_reg(tdc_pkg::CSR_MIN_COS, AREA_W'(minc[COS_W-1:0]));
   endtask

   // valid is lowered only on an idle cycle, so back-to-back items keep it high
   task automatic send_triangle(input tdc_pkg::req_payload_type p, input bit typed,
                                input tdc_pkg::kind_type k);
      tdc_pkg::rsp_payload_type e;
      while (!calm && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e.face_out = p.face_index;
      e.kind     = typed ? k : classify(p);
      expected_q = {expected_q, e};
   endtask

   function automatic tdc_pkg::req_payload_type random_triangle();
      tdc_pkg::req_payload_type p;
      int base[3], u[3], w[3], sh, mode, k;
      p = '0;
      p.face_index = INDEX_W'($urandom);
      mode = $urandom_range(9);
      sh   = $urandom_range(15);
      for (int i = 0; i < 3; i++) begin
         base[i] = $signed(16'($urandom));
         u[i] = $signed(16'($urandom)) >>> sh;
         w[i] = $signed(16'($urandom)) >>> sh;
      end
      k = $signed(3'($urandom));
      if (mode == 0) begin
         // full-range noise
         for (int i = 0; i < 3; i++) begin
            u[i] = $signed(16'($urandom)) - base[i];
            w[i] = $signed(16'($urandom)) - base[i];
         end
      end else if (mode == 1) begin
         for (int i = 0; i < 3; i++) w[i] = (k == 0) ? 0 : u[i];  // repeated vertex
      end else if (mode == 2) begin
         for (int i = 0; i < 3; i++) w[i] = u[i] * k;             // collinear
      end else if (mode == 3) begin
         for (int i = 0; i < 3; i++) w[i] = u[i] * 8 + (w[i] >>> 6); // thin sliver
      end
      p.ax = COORD_W'(base[0]);
      p.ay = COORD_W'(base[1]);
      p.az = COORD_W'(base[2]);
      p.bx = COORD_W'(base[0] + u[0]);
      p.by_coord = COORD_W'(base[1] + u[1]);
      p.bz = COORD_W'(base[2] + u[2]);
      p.cx = COORD_W'(base[0] + w[0]);
      p.cy = COORD_W'(base[1] + w[1]);
      p.cz = COORD_W'(base[2] + w[2]);
      return p;
   endfunction

   // ---------------- result side ----------------
   always @(posedge clock) begin
      if (reset || calm)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < 38);
   end

   always @(posedge clock) begin
      tdc_pkg::rsp_payload_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result transfer: face_out %0h kind %0d",
                   rsp_payload.face_out, rsp_payload.kind);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_payload.face_out !== e.face_out) begin
               $error("face_out expected %0h actual %0h", e.face_out, rsp_payload.face_out);
               errors++;
            end
            if (rsp_payload.kind !== e.kind) begin
               $error("kind expected %0d actual %0d (face %0h)", e.kind, rsp_payload.kind,
                      e.face_out);
               errors++;
            end
         end
      end
   end

   // ---------------- main sequence ----------------
   initial begin
      logic [AREA_W-1:0] area;
      int n;
      errors = 0; cycles = 0; calm = 0;
      reset = 1'b1; req_valid = 1'b0; req_payload = '0; rsp_stall = 1'b0;
      csr_we = 1'b0; csr_index = tdc_pkg::CSR_AREA_LIMIT; csr_wdata = '0;
      area_limit = '0; obtuse_cos = -16384; needle_cos = 30792;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings first
      add_row(0, -16384, 30792, tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              tdc_pkg::KIND_NONE);
      add_row(0, -16384, 30792, tri_of('hFFFFFF, 5, 5, 5, 5, 5, 5, 9, 1, 2), 1,
              tdc_pkg::KIND_NONE);
      add_row(0, -16384, 30792, tri_of(2, 0, 0, 0, 1, 0, 0, 2, 0, 0), 1,
              tdc_pkg::KIND_NEEDLE);
      add_row(0, -16384, 30792, tri_of(3, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1,
              tdc_pkg::KIND_NONE);
      add_row(0, -16384, 30792, tri_of(4, 0, 0, 0, 1000, 0, 0, -1000, 100, 0), 1,
              tdc_pkg::KIND_OBTUSE);
      add_row(0, -16384, 30792, tri_of(5, 0, 0, 0, 10000, 0, 0, 0, 100, 0), 1,
              tdc_pkg::KIND_NEEDLE);
      add_row(0, -16384, 30792, tri_of(6, -32768, -32768, -32768, 32767, 32767, 32767,
                                       -32768, 32767, -32768), 0, tdc_pkg::KIND_NONE);
      add_row(0, -16384, 30792, tri_of(7, 32767, -32768, 32767, -32768, 32767, -32768,
                                       32767, 32767, 32767), 0, tdc_pkg::KIND_NONE);
      add_row(0, -16384, 30792, tri_of(8, -32768, 0, 0, 32767, 0, 1, 0, 0, 0), 0,
              tdc_pkg::KIND_NONE);
      // area limit exactly at twice the area, then just above
      add_row(6, -16384, 30792, tri_of(9, 0, 0, 0, 2, 0, 0, 0, 3, 0), 1,
              tdc_pkg::KIND_NONE);
      add_row(7, -16384, 30792, tri_of(10, 0, 0, 0, 2, 0, 0, 0, 3, 0), 1,
              tdc_pkg::KIND_SMALL);
      add_row(7, -16384, 30792, tri_of(11, 0, 0, 0, 0, 0, 0, 0, 3, 0), 1,
              tdc_pkg::KIND_SMALL);
      // right angle sitting exactly on a zero cosine limit
      add_row(0, 0, 30792, tri_of(12, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1,
              tdc_pkg::KIND_NONE);
      add_row(0, 0, 30792, tri_of(13, 0, 0, 0, 256, 0, 0, -1, 256, 0), 1,
              tdc_pkg::KIND_OBTUSE);
      // 45 degrees exactly cannot be hit in Q1.15; probe both sides of the limit
      add_row(0, -16384, 23170, tri_of(14, 0, 0, 0, 256, 0, 0, 0, 256, 0), 0,
              tdc_pkg::KIND_NONE);
      add_row(0, -16384, 23171, tri_of(15, 0, 0, 0, 256, 0, 0, 0, 256, 0), 0,
              tdc_pkg::KIND_NONE);
      // extreme limits
      add_row('1, -32768, -32768, tri_of(16, 0, 0, 0, 32767, 0, 0, 0, 32767, 0), 0,
              tdc_pkg::KIND_NONE);
      add_row(0, 32767, 32767, tri_of(17, 1, 2, 3, 300, -20, 7, -50, 400, 9), 0,
              tdc_pkg::KIND_NONE);
      add_row(0, -32768, -32768, tri_of(18, 1, 2, 3, 300, -20, 7, -50, 400, 9), 0,
              tdc_pkg::KIND_NONE);
      add_row(0, -32768, 32767, tri_of(19, 0, 0, 0, 1, 0, 0, 2, 0, 0), 0,
              tdc_pkg::KIND_NONE);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].area != area_limit || dir_rows[i].maxc != obtuse_cos ||
             dir_rows[i].minc != needle_cos) begin
            req_valid <= 1'b0;
            load_settings(dir_rows[i].area, dir_rows[i].maxc, dir_rows[i].minc);
         end
         send_triangle(dir_rows[i].tri_in, dir_rows[i].typed, dir_rows[i].kind);
      end

      // random phases, each under its own settings
      for (int ph = 0; ph < 7; ph++) begin
         req_valid <= 1'b0;
         case (ph)
            0: load_settings(0, -16384, 30792);
            1: load_settings('1, -32768, 32767);
            2: load_settings(0, 32767, -32768);
            default: begin
               area = AREA_W'({$urandom, $urandom});
               area = area >> $urandom_range(AREA_W - 1);
               load_settings(area, $signed(16'($urandom)), $signed(16'($urandom)));
            end
         endcase
         n = (ph < 3) ? 50 : 100;
         for (int i = 0; i < n; i++) begin
            calm = (ph == 4 && i >= 20 && i < 80);
            send_triangle(random_triangle(), 0, tdc_pkg::KIND_NONE);
         end
         calm = 0;
      end
      req_valid <= 1'b0;

      wait_idle();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

FILE: triangle_degeneracy_classifier_core.f
rtl/tdc_pkg.sv
rtl/tdc_mul.sv
rtl/triangle_degeneracy_classifier_core.sv
tb/tb.sv
